@@ rtl/cube_tile_vertex_generator_defines.svh @@
// Assertion macros used by the cube tile vertex generator checker file.
`ifndef CUBE_TILE_VERTEX_GENERATOR_DEFINES_SVH
`define CUBE_TILE_VERTEX_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, idle while arst_n is low.
`define CTVG_ASSERT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ctvg assertion failed");

// Next-cycle implication, sampled on clk, idle while arst_n is low.
`define CTVG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ctvg assertion failed");

`endif

@@ rtl/ctvg_pkg.sv @@
// Shared types, constants and face tables of the cube tile vertex generator.
package ctvg_pkg;

	// Field and datapath widths.
	localparam int unsigned SUBDIV_W  = 7;
	localparam int unsigned FACE_W    = 3;
	localparam int unsigned TILE_W    = 6;
	localparam int unsigned CORNER_W  = 3;
	localparam int unsigned POS_W     = 16;
	localparam int unsigned NORM_W    = 2;
	localparam int unsigned COORD_W   = 7;
	localparam int unsigned NUM_W     = 23;
	localparam int unsigned RECIP_W   = 30;
	localparam int unsigned PROD_W    = NUM_W + RECIP_W;
	localparam int unsigned QUO_W     = 16;
	localparam int unsigned SUM_W     = 18;

	// Largest subdivision count; larger writes saturate to it.
	localparam int unsigned MAX_SUBDIV = 64;

	// Codes for faces and corners.
	localparam logic [FACE_W-1:0]   FACE_MAX    = 3'd5;
	localparam logic [CORNER_W-1:0] FIRST_CORNER = 3'd0;
	localparam logic [CORNER_W-1:0] LAST_CORNER  = 3'd5;

	// Half a cube edge in Q1.15.
	localparam logic signed [SUM_W-1:0] HALF_POS = 18'sd16384;
	localparam logic signed [SUM_W-1:0] HALF_NEG = -18'sd16384;

	// Normal component codes.
	localparam logic signed [NORM_W-1:0] NRM_ZERO = 2'sb00;
	localparam logic signed [NORM_W-1:0] NRM_POS  = 2'sb01;
	localparam logic signed [NORM_W-1:0] NRM_NEG  = 2'sb11;

	// Per-corner column step, row step and UV, bit k for corner k
	// in the order BR, TR, TL, BL, BR, TL.
	localparam logic [5:0] CORNER_DA = 6'b010011;
	localparam logic [5:0] CORNER_DB = 6'b011001;
	localparam logic [5:0] CORNER_U  = 6'b010011;
	localparam logic [5:0] CORNER_V  = 6'b100110;

	// Reciprocals ceil(2^29 / n) for n = 1..64. Multiplying a numerator below
	// 2^23 by entry n-1 and dropping 30 bits gives an exact divide by 2n.
	localparam int unsigned P29 = 32'd536870912;
	localparam logic [RECIP_W-1:0] RECIP_TAB [MAX_SUBDIV] = '{
		30'((P29 + 0) / 1),   30'((P29 + 1) / 2),   30'((P29 + 2) / 3),   30'((P29 + 3) / 4),
		30'((P29 + 4) / 5),   30'((P29 + 5) / 6),   30'((P29 + 6) / 7),   30'((P29 + 7) / 8),
		30'((P29 + 8) / 9),   30'((P29 + 9) / 10),  30'((P29 + 10) / 11), 30'((P29 + 11) / 12),
		30'((P29 + 12) / 13), 30'((P29 + 13) / 14), 30'((P29 + 14) / 15), 30'((P29 + 15) / 16),
		30'((P29 + 16) / 17), 30'((P29 + 17) / 18), 30'((P29 + 18) / 19), 30'((P29 + 19) / 20),
		30'((P29 + 20) / 21), 30'((P29 + 21) / 22), 30'((P29 + 22) / 23), 30'((P29 + 23) / 24),
		30'((P29 + 24) / 25), 30'((P29 + 25) / 26), 30'((P29 + 26) / 27), 30'((P29 + 27) / 28),
		30'((P29 + 28) / 29), 30'((P29 + 29) / 30), 30'((P29 + 30) / 31), 30'((P29 + 31) / 32),
		30'((P29 + 32) / 33), 30'((P29 + 33) / 34), 30'((P29 + 34) / 35), 30'((P29 + 35) / 36),
		30'((P29 + 36) / 37), 30'((P29 + 37) / 38), 30'((P29 + 38) / 39), 30'((P29 + 39) / 40),
		30'((P29 + 40) / 41), 30'((P29 + 41) / 42), 30'((P29 + 42) / 43), 30'((P29 + 43) / 44),
		30'((P29 + 44) / 45), 30'((P29 + 45) / 46), 30'((P29 + 46) / 47), 30'((P29 + 47) / 48),
		30'((P29 + 48) / 49), 30'((P29 + 49) / 50), 30'((P29 + 50) / 51), 30'((P29 + 51) / 52),
		30'((P29 + 52) / 53), 30'((P29 + 53) / 54), 30'((P29 + 54) / 55), 30'((P29 + 55) / 56),
		30'((P29 + 56) / 57), 30'((P29 + 57) / 58), 30'((P29 + 58) / 59), 30'((P29 + 59) / 60),
		30'((P29 + 60) / 61), 30'((P29 + 61) / 62), 30'((P29 + 62) / 63), 30'((P29 + 63) / 64)
	};

	// Which interpolated offset drives an axis: none, the column term or the row term.
	typedef enum logic [1:0] {
		SRC_NONE,
		SRC_A,
		SRC_B
	} ctvg_src_t;

	// One axis of a face: sign of the top-left corner, offset source, offset sign.
	typedef struct packed {
		logic      tl_pos;
		ctvg_src_t src;
		logic      neg;
	} ctvg_axis_t;

	// Geometry of one face.
	typedef struct packed {
		ctvg_axis_t               ax_x;
		ctvg_axis_t               ax_y;
		ctvg_axis_t               ax_z;
		logic signed [NORM_W-1:0] nx;
		logic signed [NORM_W-1:0] ny;
		logic signed [NORM_W-1:0] nz;
	} ctvg_face_t;

	// Control that travels with each vertex down the pipeline.
	typedef struct packed {
		logic [FACE_W-1:0]   face;
		logic [CORNER_W-1:0] corner;
		logic                bad;
	} ctvg_vtx_ctl_t;

	function automatic ctvg_axis_t mk_axis(input logic tl_pos, input ctvg_src_t src,
		input logic neg);
		ctvg_axis_t ax;
		ax.tl_pos = tl_pos;
		ax.src    = src;
		ax.neg    = neg;
		return ax;
	endfunction

	// Face table in the order +z, +y, +x, -x, -y, -z.
	function automatic ctvg_face_t face_info(input logic [FACE_W-1:0] face);
		ctvg_face_t f;
		f = '0;
		case (face)
			3'd0: begin
				f.ax_x = mk_axis(1'b0, SRC_A, 1'b0);
				f.ax_y = mk_axis(1'b1, SRC_B, 1'b1);
				f.ax_z = mk_axis(1'b1, SRC_NONE, 1'b0);
				f.nx = NRM_ZERO; f.ny = NRM_ZERO; f.nz = NRM_POS;
			end
			3'd1: begin
				f.ax_x = mk_axis(1'b1, SRC_A, 1'b1);
				f.ax_y = mk_axis(1'b1, SRC_NONE, 1'b0);
				f.ax_z = mk_axis(1'b1, SRC_B, 1'b1);
				f.nx = NRM_ZERO; f.ny = NRM_POS; f.nz = NRM_ZERO;
			end
			3'd2: begin
				f.ax_x = mk_axis(1'b1, SRC_NONE, 1'b0);
				f.ax_y = mk_axis(1'b1, SRC_B, 1'b1);
				f.ax_z = mk_axis(1'b1, SRC_A, 1'b1);
				f.nx = NRM_POS; f.ny = NRM_ZERO; f.nz = NRM_ZERO;
			end
			3'd3: begin
				f.ax_x = mk_axis(1'b0, SRC_NONE, 1'b0);
				f.ax_y = mk_axis(1'b1, SRC_B, 1'b1);
				f.ax_z = mk_axis(1'b0, SRC_A, 1'b0);
				f.nx = NRM_NEG; f.ny = NRM_ZERO; f.nz = NRM_ZERO;
			end
			3'd4: begin
				f.ax_x = mk_axis(1'b1, SRC_A, 1'b1);
				f.ax_y = mk_axis(1'b0, SRC_NONE, 1'b0);
				f.ax_z = mk_axis(1'b0, SRC_B, 1'b0);
				f.nx = NRM_ZERO; f.ny = NRM_NEG; f.nz = NRM_ZERO;
			end
			3'd5: begin
				f.ax_x = mk_axis(1'b1, SRC_A, 1'b1);
				f.ax_y = mk_axis(1'b1, SRC_B, 1'b1);
				f.ax_z = mk_axis(1'b0, SRC_NONE, 1'b0);
				f.nx = NRM_ZERO; f.ny = NRM_ZERO; f.nz = NRM_NEG;
			end
			default: begin
				f = '0;
			end
		endcase
		return f;
	endfunction

endpackage

@@ rtl/ctvg_seq.sv @@
// Request register and corner sequencer: turns one tile request into six vertex slots.
module ctvg_seq (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [ctvg_pkg::SUBDIV_W-1:0]          subdiv,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [ctvg_pkg::FACE_W-1:0]            face_index,
	input  logic [ctvg_pkg::TILE_W-1:0]            tile_column,
	input  logic [ctvg_pkg::TILE_W-1:0]            tile_row,
	output logic                                   vtx_valid,
	input  logic                                   vtx_ready,
	output ctvg_pkg::ctvg_vtx_ctl_t                vtx_ctl,
	output logic [ctvg_pkg::COORD_W-1:0]           coord_a,
	output logic [ctvg_pkg::COORD_W-1:0]           coord_b
);

	logic                            req_valid_q;
	logic [ctvg_pkg::FACE_W-1:0]     face_q;
	logic [ctvg_pkg::TILE_W-1:0]     col_q;
	logic [ctvg_pkg::TILE_W-1:0]     row_q;
	logic                            bad_q;
	logic [ctvg_pkg::CORNER_W-1:0]   corner_q;
	logic                            advance;
	logic                            at_last;
	logic                            in_xfer;
	logic                            req_bad;

	// A vertex slot moves on whenever the first pipeline stage can take it.
	assign advance  = req_valid_q && vtx_ready;
	assign at_last  = (corner_q == ctvg_pkg::LAST_CORNER);
	assign in_ready = !req_valid_q || (at_last && vtx_ready);
	assign in_xfer  = in_valid && in_ready;

	// The request is flagged when its face does not exist or it lies outside the grid.
	assign req_bad = (face_index > ctvg_pkg::FACE_MAX)
		|| ({1'b0, tile_column} >= subdiv)
		|| ({1'b0, tile_row} >= subdiv);

	// Valid flag and corner counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_q <= 1'b0;
			corner_q    <= ctvg_pkg::FIRST_CORNER;
		end else if (in_xfer) begin
			req_valid_q <= 1'b1;
			corner_q    <= ctvg_pkg::FIRST_CORNER;
		end else if (advance) begin
			if (at_last) begin
				req_valid_q <= 1'b0;
			end
			corner_q <= at_last ? ctvg_pkg::FIRST_CORNER : corner_q + 3'd1;
		end
	end

	// Request payload, held for all six corners.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			face_q <= face_index;
			col_q  <= tile_column;
			row_q  <= tile_row;
			bad_q  <= req_bad;
		end
	end

	// Corner column and row for the current slot.
	always_comb begin
		coord_a = {1'b0, col_q} + {6'd0, ctvg_pkg::CORNER_DA[corner_q]};
		coord_b = {1'b0, row_q} + {6'd0, ctvg_pkg::CORNER_DB[corner_q]};
		vtx_ctl.face   = face_q;
		vtx_ctl.corner = corner_q;
		vtx_ctl.bad    = bad_q;
	end

	assign vtx_valid = req_valid_q;

endmodule

@@ rtl/ctvg_div.sv @@
// Two pipeline stages that divide the corner column and row offsets by the grid size.
module ctvg_div (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [ctvg_pkg::SUBDIV_W-1:0]          subdiv,
	input  logic [ctvg_pkg::RECIP_W-1:0]           recip,
	input  logic                                   vtx_valid,
	output logic                                   vtx_ready,
	input  ctvg_pkg::ctvg_vtx_ctl_t                vtx_ctl,
	input  logic [ctvg_pkg::COORD_W-1:0]           coord_a,
	input  logic [ctvg_pkg::COORD_W-1:0]           coord_b,
	output logic                                   q_valid,
	input  logic                                   q_ready,
	output ctvg_pkg::ctvg_vtx_ctl_t                q_ctl,
	output logic [ctvg_pkg::QUO_W-1:0]             quo_a,
	output logic [ctvg_pkg::QUO_W-1:0]             quo_b
);

	logic                              v_s1;
	ctvg_pkg::ctvg_vtx_ctl_t           ctl_s1;
	logic [ctvg_pkg::NUM_W-1:0]        num_a_s1;
	logic [ctvg_pkg::NUM_W-1:0]        num_b_s1;
	logic                              v_s2;
	ctvg_pkg::ctvg_vtx_ctl_t           ctl_s2;
	logic [ctvg_pkg::QUO_W-1:0]        quo_a_s2;
	logic [ctvg_pkg::QUO_W-1:0]        quo_b_s2;
	logic                              rdy_s1;
	logic                              rdy_s2;
	logic [ctvg_pkg::NUM_W-1:0]        num_a;
	logic [ctvg_pkg::NUM_W-1:0]        num_b;
	logic [ctvg_pkg::PROD_W-1:0]       prod_a;
	logic [ctvg_pkg::PROD_W-1:0]       prod_b;

	// A stage loads when it is empty or its contents move on.
	assign rdy_s2    = !v_s2 || q_ready;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign vtx_ready = rdy_s1;

	// Rounded numerator t * 65536 + n, so that floor(num / 2n) rounds t * 32768 / n.
	assign num_a = {coord_a, 16'd0} + {16'd0, subdiv};
	assign num_b = {coord_b, 16'd0} + {16'd0, subdiv};

	// Exact division by 2n through the reciprocal, top bits kept.
	assign prod_a = {{ctvg_pkg::RECIP_W{1'b0}}, num_a_s1} * {{ctvg_pkg::NUM_W{1'b0}}, recip};
	assign prod_b = {{ctvg_pkg::RECIP_W{1'b0}}, num_b_s1} * {{ctvg_pkg::NUM_W{1'b0}}, recip};

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= vtx_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (rdy_s1 && vtx_valid) begin
			ctl_s1   <= vtx_ctl;
			num_a_s1 <= num_a;
			num_b_s1 <= num_b;
		end
		if (rdy_s2 && v_s1) begin
			ctl_s2   <= ctl_s1;
			quo_a_s2 <= prod_a[ctvg_pkg::RECIP_W +: ctvg_pkg::QUO_W];
			quo_b_s2 <= prod_b[ctvg_pkg::RECIP_W +: ctvg_pkg::QUO_W];
		end
	end

	assign q_valid = v_s2;
	assign q_ctl   = ctl_s2;
	assign quo_a   = quo_a_s2;
	assign quo_b   = quo_b_s2;

endmodule

@@ rtl/ctvg_asm.sv @@
// Final stage: forms position, normal and UV of a vertex into the output register.
module ctvg_asm (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   q_valid,
	output logic                                   q_ready,
	input  ctvg_pkg::ctvg_vtx_ctl_t                q_ctl,
	input  logic [ctvg_pkg::QUO_W-1:0]             quo_a,
	input  logic [ctvg_pkg::QUO_W-1:0]             quo_b,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [ctvg_pkg::POS_W-1:0]      pos_x,
	output logic signed [ctvg_pkg::POS_W-1:0]      pos_y,
	output logic signed [ctvg_pkg::POS_W-1:0]      pos_z,
	output logic signed [ctvg_pkg::NORM_W-1:0]     norm_x,
	output logic signed [ctvg_pkg::NORM_W-1:0]     norm_y,
	output logic signed [ctvg_pkg::NORM_W-1:0]     norm_z,
	output logic                                   tex_u,
	output logic                                   tex_v,
	output logic                                   bad_index,
	output logic                                   last
);

	logic                                 v_s3;
	logic signed [ctvg_pkg::POS_W-1:0]    pos_x_s3;
	logic signed [ctvg_pkg::POS_W-1:0]    pos_y_s3;
	logic signed [ctvg_pkg::POS_W-1:0]    pos_z_s3;
	logic signed [ctvg_pkg::NORM_W-1:0]   norm_x_s3;
	logic signed [ctvg_pkg::NORM_W-1:0]   norm_y_s3;
	logic signed [ctvg_pkg::NORM_W-1:0]   norm_z_s3;
	logic                                 tex_u_s3;
	logic                                 tex_v_s3;
	logic                                 bad_s3;
	logic                                 last_s3;
	logic                                 rdy_s3;
	ctvg_pkg::ctvg_face_t                 fi;
	logic signed [ctvg_pkg::POS_W-1:0]    px;
	logic signed [ctvg_pkg::POS_W-1:0]    py;
	logic signed [ctvg_pkg::POS_W-1:0]    pz;

	// Corner position on one axis: top-left corner plus or minus the selected offset.
	function automatic logic signed [ctvg_pkg::POS_W-1:0] axis_pos(
		input ctvg_pkg::ctvg_axis_t ax,
		input logic [ctvg_pkg::QUO_W-1:0] qa,
		input logic [ctvg_pkg::QUO_W-1:0] qb);
		logic signed [ctvg_pkg::SUM_W-1:0] base;
		logic signed [ctvg_pkg::SUM_W-1:0] term;
		logic signed [ctvg_pkg::SUM_W-1:0] sum;
		base = ax.tl_pos ? ctvg_pkg::HALF_POS : ctvg_pkg::HALF_NEG;
		case (ax.src)
			ctvg_pkg::SRC_A: term = $signed({2'b00, qa});
			ctvg_pkg::SRC_B: term = $signed({2'b00, qb});
			default:         term = '0;
		endcase
		sum = ax.neg ? (base - term) : (base + term);
		return sum[ctvg_pkg::POS_W-1:0];
	endfunction

	assign rdy_s3  = !v_s3 || out_ready;
	assign q_ready = rdy_s3;

	// Face geometry and per-axis positions.
	always_comb begin
		fi = ctvg_pkg::face_info(q_ctl.face);
		px = axis_pos(fi.ax_x, quo_a, quo_b);
		py = axis_pos(fi.ax_y, quo_a, quo_b);
		pz = axis_pos(fi.ax_z, quo_a, quo_b);
	end

	// Output valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= q_valid;
		end
	end

	// Output payload; a flagged request carries zero geometry.
	always_ff @(posedge clk) begin
		if (rdy_s3 && q_valid) begin
			pos_x_s3  <= q_ctl.bad ? '0 : px;
			pos_y_s3  <= q_ctl.bad ? '0 : py;
			pos_z_s3  <= q_ctl.bad ? '0 : pz;
			norm_x_s3 <= q_ctl.bad ? ctvg_pkg::NRM_ZERO : fi.nx;
			norm_y_s3 <= q_ctl.bad ? ctvg_pkg::NRM_ZERO : fi.ny;
			norm_z_s3 <= q_ctl.bad ? ctvg_pkg::NRM_ZERO : fi.nz;
			tex_u_s3  <= !q_ctl.bad && ctvg_pkg::CORNER_U[q_ctl.corner];
			tex_v_s3  <= !q_ctl.bad && ctvg_pkg::CORNER_V[q_ctl.corner];
			bad_s3    <= q_ctl.bad;
			last_s3   <= (q_ctl.corner == ctvg_pkg::LAST_CORNER);
		end
	end

	assign out_valid = v_s3;
	assign pos_x     = pos_x_s3;
	assign pos_y     = pos_y_s3;
	assign pos_z     = pos_z_s3;
	assign norm_x    = norm_x_s3;
	assign norm_y    = norm_y_s3;
	assign norm_z    = norm_z_s3;
	assign tex_u     = tex_u_s3;
	assign tex_v     = tex_v_s3;
	assign bad_index = bad_s3;
	assign last      = last_s3;

endmodule

@@ rtl/cube_tile_vertex_generator.sv @@
// Top level of the cube tile vertex generator: config register and vertex pipeline.
//
//   channel   signals                                   direction
//   config    subdivisions_we, subdivisions             in, write only
//   request   in_valid/in_ready, face_index, tile_*     in
//   vertex    out_valid/out_ready, pos_*, norm_*, ...   out
//
// Each request yields six vertices, one per cycle from the corner sequencer unless
// stalled; a new request is taken as the last corner leaves, so the sequencer sets
// the rate. Each vertex passes the request, divider and output registers.
// Reset clears all valid bits and sets the grid size to one.
// A low out_ready freezes every stage in place; bubbles still close up behind it.
module cube_tile_vertex_generator (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   subdivisions_we,
	input  logic [ctvg_pkg::SUBDIV_W-1:0]          subdivisions,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [ctvg_pkg::FACE_W-1:0]            face_index,
	input  logic [ctvg_pkg::TILE_W-1:0]            tile_column,
	input  logic [ctvg_pkg::TILE_W-1:0]            tile_row,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [ctvg_pkg::POS_W-1:0]      pos_x,
	output logic signed [ctvg_pkg::POS_W-1:0]      pos_y,
	output logic signed [ctvg_pkg::POS_W-1:0]      pos_z,
	output logic signed [ctvg_pkg::NORM_W-1:0]     norm_x,
	output logic signed [ctvg_pkg::NORM_W-1:0]     norm_y,
	output logic signed [ctvg_pkg::NORM_W-1:0]     norm_z,
	output logic                                   tex_u,
	output logic                                   tex_v,
	output logic                                   bad_index,
	output logic                                   last
);

	logic [ctvg_pkg::SUBDIV_W-1:0]   subdiv_q;
	logic [ctvg_pkg::RECIP_W-1:0]    recip_q;
	logic [ctvg_pkg::SUBDIV_W-1:0]   subdiv_sat;
	logic [ctvg_pkg::SUBDIV_W-1:0]   subdiv_m1;
	logic                            vtx_valid;
	logic                            vtx_ready;
	ctvg_pkg::ctvg_vtx_ctl_t         vtx_ctl;
	logic [ctvg_pkg::COORD_W-1:0]    coord_a;
	logic [ctvg_pkg::COORD_W-1:0]    coord_b;
	logic                            q_valid;
	logic                            q_ready;
	ctvg_pkg::ctvg_vtx_ctl_t         q_ctl;
	logic [ctvg_pkg::QUO_W-1:0]      quo_a;
	logic [ctvg_pkg::QUO_W-1:0]      quo_b;

	// Saturate the written grid size and look up its reciprocal once per write.
	assign subdiv_sat = (subdivisions > ctvg_pkg::SUBDIV_W'(ctvg_pkg::MAX_SUBDIV))
		? ctvg_pkg::SUBDIV_W'(ctvg_pkg::MAX_SUBDIV) : subdivisions;
	assign subdiv_m1  = subdiv_sat - 7'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subdiv_q <= 7'd1;
			recip_q  <= ctvg_pkg::RECIP_TAB[0];
		end else if (subdivisions_we) begin
			subdiv_q <= subdiv_sat;
			recip_q  <= ctvg_pkg::RECIP_TAB[subdiv_m1[5:0]];
		end
	end

	ctvg_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.subdiv      (subdiv_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.face_index  (face_index),
		.tile_column (tile_column),
		.tile_row    (tile_row),
		.vtx_valid   (vtx_valid),
		.vtx_ready   (vtx_ready),
		.vtx_ctl     (vtx_ctl),
		.coord_a     (coord_a),
		.coord_b     (coord_b)
	);

	ctvg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.subdiv    (subdiv_q),
		.recip     (recip_q),
		.vtx_valid (vtx_valid),
		.vtx_ready (vtx_ready),
		.vtx_ctl   (vtx_ctl),
		.coord_a   (coord_a),
		.coord_b   (coord_b),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_ctl     (q_ctl),
		.quo_a     (quo_a),
		.quo_b     (quo_b)
	);

	ctvg_asm u_asm (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_ctl     (q_ctl),
		.quo_a     (quo_a),
		.quo_b     (quo_b),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.norm_x    (norm_x),
		.norm_y    (norm_y),
		.norm_z    (norm_z),
		.tex_u     (tex_u),
		.tex_v     (tex_v),
		.bad_index (bad_index),
		.last      (last)
	);

endmodule

@@ rtl/ctvg_checker.sv @@
// Port-level checker for the cube tile vertex generator, bound to the top level.
`include "cube_tile_vertex_generator_defines.svh"

module ctvg_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   out_valid,
	input  logic                                   out_ready,
	input  logic signed [ctvg_pkg::POS_W-1:0]      pos_x,
	input  logic signed [ctvg_pkg::POS_W-1:0]      pos_y,
	input  logic signed [ctvg_pkg::POS_W-1:0]      pos_z,
	input  logic signed [ctvg_pkg::NORM_W-1:0]     norm_x,
	input  logic signed [ctvg_pkg::NORM_W-1:0]     norm_y,
	input  logic signed [ctvg_pkg::NORM_W-1:0]     norm_z,
	input  logic                                   tex_u,
	input  logic                                   tex_v,
	input  logic                                   bad_index,
	input  logic                                   last
);

	logic [ctvg_pkg::CORNER_W-1:0]                          out_cnt_q;
	logic                                                   out_xfer;
	logic [3*ctvg_pkg::POS_W+3*ctvg_pkg::NORM_W+3:0]        out_word;
	logic                                                   geom_zero;
	logic [2:0]                                             norm_nz;

	assign out_xfer = out_valid && out_ready;

	// Whole vertex payload, its zero-geometry test and the nonzero normal axes.
	assign out_word  = {pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
		tex_u, tex_v, bad_index, last};
	assign geom_zero = (pos_x == '0) && (pos_y == '0) && (pos_z == '0)
		&& (norm_x == '0) && (norm_y == '0) && (norm_z == '0) && !tex_u && !tex_v;
	assign norm_nz   = {norm_x != '0, norm_y != '0, norm_z != '0};

	// Count vertex transfers within the current tile.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= ctvg_pkg::FIRST_CORNER;
		end else if (out_xfer) begin
			out_cnt_q <= last ? ctvg_pkg::FIRST_CORNER : out_cnt_q + 3'd1;
		end
	end

	// A stalled vertex keeps its payload.
	`CTVG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))

	// The last flag falls exactly on the sixth vertex of every tile.
	`CTVG_ASSERT(a_last_sixth, out_xfer, last == (out_cnt_q == ctvg_pkg::LAST_CORNER))

	// A flagged tile carries no geometry.
	`CTVG_ASSERT(a_bad_zero, out_valid && bad_index, geom_zero)

	// A good vertex has exactly one nonzero normal axis.
	`CTVG_ASSERT(a_norm_axis, out_valid && !bad_index, $countones(norm_nz) == 1)

endmodule

bind cube_tile_vertex_generator ctvg_checker u_ctvg_checker (.*);
